[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cri_pkg.sv]
// Shared types and constants of the Catmull-Rom interpolator.
package cri_pkg;

    localparam int COORD_W   = 32;
    localparam int STEPS_W   = 6;
    localparam logic [STEPS_W-1:0] MAX_STEPS = 6'd63;
    localparam logic [STEPS_W-1:0] STEPS_RST = 6'd63;

    // u in Q1.16, up to and including 1.0
    localparam int U_W = 17;
    localparam logic [U_W-1:0] U_ONE = 17'h10000;
    localparam int CNT_W = $clog2(U_W);

    // doubled coefficients and Horner accumulator
    localparam int COEF_W = 36;
    localparam int H_W    = 38;
    localparam int PROD_W = H_W + U_W + 1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [H_W-1:0]     h_t;

    typedef enum logic [1:0] {
        STG_FIRST,
        STG_SECOND,
        STG_THIRD
    } stage_t;

    typedef struct packed {
        logic   coef1;
        logic   coef2;
        logic   mul;
        logic   axis;
        stage_t stage;
    } hcmd_t;

endpackage

[hw/rtl/catmull_rom_interpolator.sv]
// Top level: window store, node sequencer and output register.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_we                 cfg_wdata (steps)
//  in       in         in_valid / in_stall    point_x, point_y
//  out      out        out_valid / out_stall  node_x, node_y, last_node
//
// The first three way points are stored in the window, no words out.
// Each later point runs a setup (coefficients, and the divider forming
// 65536/steps), then per node six issues to the one shared multiplier,
// a write-back step and an output step.
// in_stall is high from an accepted later point until its last node is registered.
// out_stall holds the output register; the sequencer waits on it at each node.
// Reset clears the window, point count and steps (to 63); no clearing pass.
module catmull_rom_interpolator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cri_pkg::STEPS_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cri_pkg::coord_t             point_x,
    input  cri_pkg::coord_t             point_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cri_pkg::coord_t             node_x,
    output cri_pkg::coord_t             node_y,
    output logic                        last_node
);

    localparam logic [1:0] SEEN_FULL = 2'd3;
    localparam logic [2:0] OP_LAST   = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF1,
        S_COEF2,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [cri_pkg::STEPS_W-1:0]   steps_reg, steps_next;
    logic [1:0]                    seen_reg, seen_next;
    cri_pkg::coord_t               win_x_reg [3];
    cri_pkg::coord_t               win_x_next [3];
    cri_pkg::coord_t               win_y_reg [3];
    cri_pkg::coord_t               win_y_next [3];
    cri_pkg::coord_t               p3x_reg, p3x_next;
    cri_pkg::coord_t               p3y_reg, p3y_next;
    logic [cri_pkg::STEPS_W-1:0]   n_reg, n_next;
    logic [cri_pkg::STEPS_W-1:0]   idx_reg, idx_next;
    logic [cri_pkg::U_W-1:0]       u_reg, u_next;
    logic [cri_pkg::STEPS_W-1:0]   ur_reg, ur_next;
    logic [2:0]                    op_reg, op_next;
    logic                          out_valid_reg, out_valid_next;
    cri_pkg::coord_t               node_x_reg, node_x_next;
    cri_pkg::coord_t               node_y_reg, node_y_next;
    logic                          last_reg, last_next;

    logic [cri_pkg::STEPS_W-1:0]   steps_eff;
    logic                          div_start;
    logic                          div_busy;
    logic [cri_pkg::U_W-1:0]       div_quo;
    logic [cri_pkg::STEPS_W-1:0]   div_rem;
    logic [cri_pkg::STEPS_W:0]     ur_sum;
    cri_pkg::hcmd_t                hcmd;
    cri_pkg::coord_t               hpt_x [4];
    cri_pkg::coord_t               hpt_y [4];
    cri_pkg::h_t                   h_x;
    cri_pkg::h_t                   h_y;
    logic                          is_last;

    // floor(h / 2) + p1, saturated to the 32-bit range
    function automatic cri_pkg::coord_t make_node(cri_pkg::h_t h, cri_pkg::coord_t p1);
        logic signed [cri_pkg::H_W:0] s;
        logic [cri_pkg::H_W-cri_pkg::COORD_W+1:0] top;
        cri_pkg::coord_t r;
        s = $signed({{2{h[cri_pkg::H_W-1]}}, h[cri_pkg::H_W-1:1]})
            + $signed({{(cri_pkg::H_W+1-cri_pkg::COORD_W){p1[cri_pkg::COORD_W-1]}}, p1});
        top = s[cri_pkg::H_W:cri_pkg::COORD_W-1];
        if ((&top) || !(|top))
        begin
            r = s[cri_pkg::COORD_W-1:0];
        end
        else if (s[cri_pkg::H_W])
        begin
            r = {1'b1, {(cri_pkg::COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(cri_pkg::COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        if (steps_reg == '0)
        begin
            steps_eff = cri_pkg::STEPS_W'(1);
        end
        else if (steps_reg > cri_pkg::MAX_STEPS)
        begin
            steps_eff = cri_pkg::MAX_STEPS;
        end
        else
        begin
            steps_eff = steps_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign div_start = (state_reg == S_IDLE) && in_valid && (seen_reg == SEEN_FULL);
    assign is_last   = (idx_reg == n_reg);
    assign ur_sum    = {1'b0, ur_reg} + {1'b0, div_rem};

    assign hpt_x[0] = win_x_reg[0];
    assign hpt_x[1] = win_x_reg[1];
    assign hpt_x[2] = win_x_reg[2];
    assign hpt_x[3] = p3x_reg;
    assign hpt_y[0] = win_y_reg[0];
    assign hpt_y[1] = win_y_reg[1];
    assign hpt_y[2] = win_y_reg[2];
    assign hpt_y[3] = p3y_reg;

    cri_udiv u_udiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (steps_eff),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    cri_horner u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hcmd),
        .pt_x  (hpt_x),
        .pt_y  (hpt_y),
        .u     (u_reg),
        .h_x   (h_x),
        .h_y   (h_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        seen_next      = seen_reg;
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        p3x_next       = p3x_reg;
        p3y_next       = p3y_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        u_next         = u_reg;
        ur_next        = ur_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        node_x_next    = node_x_reg;
        node_y_next    = node_y_reg;
        last_next      = last_reg;
        hcmd           = '{coef1: 1'b0, coef2: 1'b0, mul: 1'b0,
                           axis: cri_pkg::AXIS_X, stage: cri_pkg::STG_FIRST};

        if (cfg_we)
        begin
            steps_next = cfg_wdata;
        end

        // drop the word the consumer takes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (seen_reg != SEEN_FULL)
                    begin
                        win_x_next[seen_reg] = point_x;
                        win_y_next[seen_reg] = point_y;
                        seen_next            = seen_reg + 1'b1;
                    end
                    else
                    begin
                        p3x_next   = point_x;
                        p3y_next   = point_y;
                        n_next     = steps_eff;
                        state_next = S_COEF1;
                    end
                end
            end
            S_COEF1:
            begin
                hcmd.coef1 = 1'b1;
                state_next = S_COEF2;
            end
            S_COEF2:
            begin
                hcmd.coef2 = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    u_next     = '0;
                    ur_next    = '0;
                    idx_next   = '0;
                    op_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // issue x and y alternately; each write-back lands before its next use
                if (op_reg != OP_LAST)
                begin
                    hcmd.mul  = 1'b1;
                    hcmd.axis = op_reg[0];
                    case (op_reg[2:1])
                        2'd0:    hcmd.stage = cri_pkg::STG_FIRST;
                        2'd1:    hcmd.stage = cri_pkg::STG_SECOND;
                        default: hcmd.stage = cri_pkg::STG_THIRD;
                    endcase
                    op_next = op_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    node_x_next    = make_node(h_x, win_x_reg[1]);
                    node_y_next    = make_node(h_y, win_y_reg[1]);
                    last_next      = is_last;
                    if (is_last)
                    begin
                        win_x_next[0] = win_x_reg[1];
                        win_x_next[1] = win_x_reg[2];
                        win_x_next[2] = p3x_reg;
                        win_y_next[0] = win_y_reg[1];
                        win_y_next[1] = win_y_reg[2];
                        win_y_next[2] = p3y_reg;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        // advance u by 65536/n, carrying the remainder
                        if (ur_sum >= {1'b0, n_reg})
                        begin
                            ur_next = ur_sum[cri_pkg::STEPS_W-1:0] - n_reg;
                            u_next  = u_reg + div_quo + 1'b1;
                        end
                        else
                        begin
                            ur_next = ur_sum[cri_pkg::STEPS_W-1:0];
                            u_next  = u_reg + div_quo;
                        end
                        idx_next   = idx_reg + 1'b1;
                        op_next    = '0;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= cri_pkg::STEPS_RST;
            seen_reg      <= '0;
            win_x_reg     <= '{default: '0};
            win_y_reg     <= '{default: '0};
            p3x_reg       <= '0;
            p3y_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            u_reg         <= '0;
            ur_reg        <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
            node_x_reg    <= '0;
            node_y_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            seen_reg      <= seen_next;
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
            p3x_reg       <= p3x_next;
            p3y_reg       <= p3y_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            u_reg         <= u_next;
            ur_reg        <= ur_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            node_x_reg    <= node_x_next;
            node_y_reg    <= node_y_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign node_x    = node_x_reg;
    assign node_y    = node_y_reg;
    assign last_node = last_reg;

endmodule

[hw/rtl/cri_udiv.sv]
// Restoring divider that forms 65536 / steps, one quotient bit a cycle.
module cri_udiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cri_pkg::STEPS_W-1:0] divisor,
    output logic                        busy,
    output logic [cri_pkg::U_W-1:0]     quo,
    output logic [cri_pkg::STEPS_W-1:0] rem
);

    logic                        busy_reg;
    logic [cri_pkg::CNT_W-1:0]   cnt_reg;
    logic [cri_pkg::STEPS_W-1:0] dvs_reg;
    logic [cri_pkg::STEPS_W-1:0] rem_reg;
    logic [cri_pkg::U_W-1:0]     quo_reg;

    logic [cri_pkg::STEPS_W:0]   trial;
    logic [cri_pkg::STEPS_W:0]   diff;
    logic                        qbit;

    assign trial = {rem_reg, cri_pkg::U_ONE[cnt_reg]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cri_pkg::CNT_W'(cri_pkg::U_W - 1);
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[cri_pkg::STEPS_W-1:0] : trial[cri_pkg::STEPS_W-1:0];
            quo_reg <= {quo_reg[cri_pkg::U_W-2:0], qbit};
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[hw/rtl/cri_horner.sv]
// Coefficient setup and the shared multiply-floor-add unit for both axes.
module cri_horner (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cri_pkg::hcmd_t          cmd,
    input  cri_pkg::coord_t         pt_x [4],
    input  cri_pkg::coord_t         pt_y [4],
    input  logic [cri_pkg::U_W-1:0] u,
    output cri_pkg::h_t             h_x,
    output cri_pkg::h_t             h_y
);

    cri_pkg::coef_t e [2][4];

    cri_pkg::coef_t d30_reg [2];
    cri_pkg::coef_t d12_reg [2];
    cri_pkg::coef_t b1_reg  [2];
    cri_pkg::coef_t b2_reg  [2];
    cri_pkg::coef_t c0_reg  [2];
    cri_pkg::coef_t ca_reg  [2];
    cri_pkg::coef_t cb_reg  [2];
    cri_pkg::coef_t cc_reg  [2];
    cri_pkg::h_t    h_reg   [2];

    cri_pkg::h_t                        mcand;
    cri_pkg::h_t                        addend;
    logic signed [cri_pkg::PROD_W-1:0]  prod;
    logic signed [cri_pkg::PROD_W-1:0]  prod_reg;
    cri_pkg::h_t                        add_reg;
    logic                               wb_vld_reg;
    logic                               wb_axis_reg;
    cri_pkg::h_t                        hsum;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            e[0][k] = cri_pkg::COEF_W'(pt_x[k]);
            e[1][k] = cri_pkg::COEF_W'(pt_y[k]);
        end
    end

    // Setup registers the partial terms, then A, B, C (all doubled).
    always_ff @(posedge clk)
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            if (cmd.coef1)
            begin
                d30_reg[ax] <= e[ax][3] - e[ax][0];
                d12_reg[ax] <= e[ax][1] - e[ax][2];
                b1_reg[ax]  <= (e[ax][0] <<< 1) - e[ax][3];
                b2_reg[ax]  <= ((e[ax][2] - e[ax][1]) <<< 2) - e[ax][1];
                c0_reg[ax]  <= e[ax][2] - e[ax][0];
            end
            if (cmd.coef2)
            begin
                ca_reg[ax] <= d30_reg[ax] + d12_reg[ax] + (d12_reg[ax] <<< 1);
                cb_reg[ax] <= b1_reg[ax] + b2_reg[ax];
                cc_reg[ax] <= c0_reg[ax];
            end
        end
    end

    always_comb
    begin
        if (cmd.stage == cri_pkg::STG_FIRST)
        begin
            mcand = cri_pkg::H_W'(ca_reg[cmd.axis]);
        end
        else
        begin
            mcand = h_reg[cmd.axis];
        end
        case (cmd.stage)
            cri_pkg::STG_FIRST:  addend = cri_pkg::H_W'(cb_reg[cmd.axis]);
            cri_pkg::STG_SECOND: addend = cri_pkg::H_W'(cc_reg[cmd.axis]);
            default:             addend = '0;
        endcase
    end

    // One 38 x 18 signed multiplier, shared by every Horner step of both axes.
    assign prod = mcand * $signed({1'b0, u});

    // Dropping the low 16 bits of a two's complement product floors it.
    assign hsum = $signed(prod_reg[cri_pkg::H_W+15:16]) + add_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_vld_reg  <= 1'b0;
            wb_axis_reg <= cri_pkg::AXIS_X;
        end
        else
        begin
            wb_vld_reg  <= cmd.mul;
            wb_axis_reg <= cmd.axis;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= prod;
            add_reg  <= addend;
        end
        if (wb_vld_reg)
        begin
            h_reg[wb_axis_reg] <= hsum;
        end
    end

    assign h_x = h_reg[cri_pkg::AXIS_X];
    assign h_y = h_reg[cri_pkg::AXIS_Y];

endmodule

[hw/rtl/cri_checker.sv]
// Port-level checker for the Catmull-Rom interpolator, bound to the top level.
`include "assert_macros.svh"

module cri_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input cri_pkg::coord_t node_x,
    input cri_pkg::coord_t node_y,
    input logic            last_node
);

    `ASSERT_NXT(a_out_valid_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
    `ASSERT_NXT(a_out_word_hold, out_valid && out_stall, $stable(node_x) && $stable(node_y) && $stable(last_node), "stalled output word changed")
    `ASSERT_IMP(a_busy_mid_run, out_valid && !last_node, in_stall, "input open while a run is unfinished")
    `ASSERT_IMP(a_busy_after_accept, $rose(in_stall), $past(in_valid), "in_stall rose without an accepted point")

endmodule

bind catmull_rom_interpolator cri_checker u_cri_checker (.*);

[tb/catmull_rom_interpolator_tb.sv]
// Testbench for the Catmull-Rom interpolator: directed and random way points, self-checking.
`timescale 1ns / 100ps

module catmull_rom_interpolator_tb;

    localparam cri_pkg::coord_t C_MAX        = 32'sh7fffffff;
    localparam cri_pkg::coord_t C_MIN        = 32'sh80000000;
    localparam int              CFG_SETTLE   = 40;
    localparam int              FINAL_SETTLE = 600;
    localparam int              CYCLE_LIMIT  = 3000000;

    typedef struct {
        cri_pkg::coord_t x;
        cri_pkg::coord_t y;
        logic            last;
    } node_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [cri_pkg::STEPS_W-1:0]   cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    cri_pkg::coord_t               point_x = '0;
    cri_pkg::coord_t               point_y = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    cri_pkg::coord_t               node_x;
    cri_pkg::coord_t               node_y;
    logic                          last_node;

    // shadow copy of the block's state
    cri_pkg::coord_t               win_x[3] = '{default: '0};
    cri_pkg::coord_t               win_y[3] = '{default: '0};
    int                            held = 0;
    logic [cri_pkg::STEPS_W-1:0]   steps_cfg = cri_pkg::STEPS_RST;

    node_t                         node_q[$];
    int                            mismatches = 0;
    int                            cycle_count = 0;
    int                            src_idle_pct = 0;
    int                            snk_stall_pct = 0;

    catmull_rom_interpolator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .node_x    (node_x),
        .node_y    (node_y),
        .last_node (last_node)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One axis of one node: Horner on the doubled coefficients, floored products.
    function automatic cri_pkg::coord_t spline_axis(input cri_pkg::coord_t p0,
                                                    input cri_pkg::coord_t p1,
                                                    input cri_pkg::coord_t p2,
                                                    input cri_pkg::coord_t p3,
                                                    input longint u);
        longint a;
        longint b;
        longint c;
        longint h;
        longint r;
        a = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
        b = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
        c = longint'(p2) - longint'(p0);
        h = ((a * u) >>> 16) + b;
        h = ((h * u) >>> 16) + c;
        h = (h * u) >>> 16;
        r = (h >>> 1) + longint'(p1);
        if (r > longint'(C_MAX))
            return C_MAX;
        if (r < longint'(C_MIN))
            return C_MIN;
        return cri_pkg::coord_t'(r);
    endfunction

    // Queue the nodes one accepted way point produces and shift it into the window.
    function automatic void predict_segment(input cri_pkg::coord_t px,
                                            input cri_pkg::coord_t py);
        node_t  nd;
        int     n;
        longint u;
        if (held < 3)
        begin
            win_x[held] = px;
            win_y[held] = py;
            held++;
        end
        else
        begin
            n = (steps_cfg == 0) ? 1 : int'(steps_cfg);
            for (int i = 0; i <= n; i++)
            begin
                u       = (longint'(i) << 16) / n;
                nd.x    = spline_axis(win_x[0], win_x[1], win_x[2], px, u);
                nd.y    = spline_axis(win_y[0], win_y[1], win_y[2], py, u);
                nd.last = (i == n);
                node_q.insert(node_q.size(), nd);
            end
            win_x[0] = win_x[1];
            win_x[1] = win_x[2];
            win_x[2] = px;
            win_y[0] = win_y[1];
            win_y[1] = win_y[2];
            win_y[2] = py;
        end
    endfunction

    function automatic cri_pkg::coord_t rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return cri_pkg::coord_t'($urandom);
            5, 6:
                return cri_pkg::coord_t'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
            7:
            begin
                case ($urandom_range(3))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default:
                return cri_pkg::coord_t'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
        endcase
    endfunction

    function automatic logic [cri_pkg::STEPS_W-1:0] pick_steps();
        case ($urandom_range(9))
            0:       return '0;
            1:       return cri_pkg::MAX_STEPS;
            2:       return cri_pkg::STEPS_W'($urandom_range(1, 63));
            default: return cri_pkg::STEPS_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Drive one way point and hold it until the block takes the word.
    task automatic send_point(input cri_pkg::coord_t px, input cri_pkg::coord_t py);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= px;
        point_y  <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_segment(px, py);
    endtask

    // Drop valid and hold off until every expected node is out and the block is idle.
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (node_q.size() != 0 || in_stall)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_steps(input logic [cri_pkg::STEPS_W-1:0] value);
        wait_drained(CFG_SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        steps_cfg = value;
    endtask

    // First three points fill the window and give no nodes; the fourth gives the first segment.
    task automatic test_window_fill();
        send_point('0, '0);
        send_point(C_MAX, C_MIN);
        send_point(C_MIN, C_MAX);
        send_point(32'sd1, -32'sd1);
    endtask

    task automatic test_extreme_points();
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MIN);
        send_point('0, -32'sd1);
    endtask

    task automatic test_short_steps();
        write_steps('0);
        send_point(32'sh00010000, -32'sh00010000);
        send_point(C_MAX, '0);
        write_steps(6'd1);
        send_point(-32'sd1, 32'sd1);
        send_point(C_MIN, C_MAX);
        write_steps(6'd2);
        send_point(32'sh12345678, 32'shedcba987);
    endtask

    // Opposite extremes around a flat span push the curve past both rails.
    task automatic test_saturation();
        write_steps(6'd7);
        send_point(C_MIN, C_MAX);
        send_point(C_MAX, C_MIN);
        send_point(C_MAX, C_MIN);
        send_point(C_MIN, C_MAX);
        send_point(C_MIN, C_MAX);
    endtask

    task automatic test_random_traffic();
        int phase_src[4] = '{0, 46, 0, 7};
        int phase_snk[4] = '{0, 0, 46, 7};
        int left;
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = phase_src[ph];
            snk_stall_pct = phase_snk[ph];
            left = 0;
            for (int k = 0; k < 112; k++)
            begin
                if (left == 0)
                begin
                    write_steps(pick_steps());
                    left = $urandom_range(20, 35);
                end
                left--;
                send_point(rand_coord(), rand_coord());
            end
        end
    endtask

    always @(posedge clk)
    begin : check_nodes
        node_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (node_q.size() == 0)
            begin
                $display("%0t: unexpected node expected none got x=%h y=%h last=%b",
                         $time, node_x, node_y, last_node);
                mismatches++;
            end
            else
            begin
                want = node_q.pop_front();
                if (node_x !== want.x)
                begin
                    $display("%0t: node_x expected %h got %h", $time, want.x, node_x);
                    mismatches++;
                end
                if (node_y !== want.y)
                begin
                    $display("%0t: node_y expected %h got %h", $time, want.y, node_y);
                    mismatches++;
                end
                if (last_node !== want.last)
                begin
                    $display("%0t: last_node expected %b got %b", $time, want.last, last_node);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("catmull_rom_interpolator_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_fill();
        test_extreme_points();
        test_short_steps();
        test_saturation();
        test_random_traffic();
        wait_drained(FINAL_SETTLE);
        if (mismatches == 0 && node_q.size() == 0)
            $display("catmull_rom_interpolator_tb: done, clean");
        else
            $display("catmull_rom_interpolator_tb: done, errors");
        $finish;
    end

endmodule
